FILE: sv/sas_pkg.sv
// Shared types and constants of the sprite animation sequencer.
`default_nettype none

package sas_pkg;

    localparam int unsigned NUM_ANIMS_DEF   = 16;
    localparam int unsigned FRAME_SLOTS_DEF = 256;
    localparam int unsigned TEX_BITS_DEF    = 8;

    // The number of descriptor indexes the 4-bit id field can reach.
    localparam int unsigned ID_SPACE = 16;

    localparam int unsigned CMDQ_DEPTH = 2;
    localparam int unsigned RESQ_DEPTH = 4;

    localparam logic [24:0] ELAPSED_MAX = '1;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_SELECT   = 2'd1,
        CMD_WR_DESC  = 2'd2,
        CMD_WR_FRAME = 2'd3
    } t_cmd_kind;

    // Frame count is kept as the index of the last frame (count - 1).
    typedef struct packed {
        logic [7:0]  base;
        logic [7:0]  last;
        logic [23:0] tpf;
        logic        rev;
        logic        loop;
        logic [7:0]  loops;
        logic        block;
    } t_desc;

    typedef struct packed {
        t_cmd_kind   kind;
        logic        id_ok;
        logic [3:0]  id;
        logic [15:0] delta;
        logic        slot_ok;
        logic [7:0]  slot;
        logic [7:0]  tex;
        t_desc       desc;
    } t_cmd;

    typedef struct packed {
        logic [7:0] texture_index;
        logic       texture_valid;
        logic [7:0] frame_position;
        logic       finished;
        logic       is_blocking;
        logic       change_taken;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/sas_fifo.sv
// Small first-word-fall-through queue built from registers.
`default_nettype none

module sas_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    output logic                            o_full,
    input  wire logic                       i_pop,
    output logic [WIDTH-1:0]                o_data,
    output logic                            o_empty,
    output logic [$clog2(DEPTH):0]          o_count
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [AW:0]      r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = do_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/sas_front.sv
// Front end: decodes and range-checks incoming commands and queues them.
`default_nettype none

module sas_front import sas_pkg::*; #(
    parameter int unsigned NUM_ANIMS   = NUM_ANIMS_DEF,
    parameter int unsigned FRAME_SLOTS = FRAME_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [1:0]  i_command,
    input  wire logic [3:0]  i_anim_id,
    input  wire logic [15:0] i_delta_time,
    input  wire logic [7:0]  i_frame_slot,
    input  wire logic [7:0]  i_texture_id,
    input  wire logic [7:0]  i_frame_base,
    input  wire logic [8:0]  i_frame_count,
    input  wire logic [23:0] i_time_per_frame,
    input  wire logic        i_reverse_flag,
    input  wire logic        i_loop_flag,
    input  wire logic [7:0]  i_loop_count,
    input  wire logic        i_block_flag,
    input  wire logic        i_pop,
    output t_cmd             o_cmd,
    output logic             o_empty
);

    t_cmd             cmd_in;
    logic [$bits(t_cmd)-1:0] q_out;

    always_comb begin
        cmd_in.kind    = t_cmd_kind'(i_command);
        cmd_in.id_ok   = (32'(i_anim_id) < NUM_ANIMS);
        cmd_in.id      = i_anim_id;
        cmd_in.delta   = i_delta_time;
        cmd_in.slot_ok = (32'(i_frame_slot) < FRAME_SLOTS);
        cmd_in.slot    = i_frame_slot;
        cmd_in.tex     = i_texture_id;

        cmd_in.desc.base = i_frame_base;
        // A count of zero behaves as one frame, anything past 256 as 256.
        if (i_frame_count == '0) begin
            cmd_in.desc.last = '0;
        end else if (i_frame_count[8]) begin
            cmd_in.desc.last = 8'hFF;
        end else begin
            cmd_in.desc.last = 8'(i_frame_count - 9'd1);
        end
        cmd_in.desc.tpf   = i_time_per_frame;
        cmd_in.desc.rev   = i_reverse_flag;
        cmd_in.desc.loop  = i_loop_flag;
        cmd_in.desc.loops = i_loop_count;
        cmd_in.desc.block = i_block_flag;
    end

    sas_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd_in),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (q_out),
        .o_empty (o_empty),
        .o_count ()
    );

    assign o_cmd = t_cmd'(q_out);

endmodule

`default_nettype wire

FILE: sv/sas_back.sv
// Back end: runs commands against the animation state, frame table and descriptor table.
`default_nettype none

module sas_back import sas_pkg::*; #(
    parameter int unsigned NUM_ANIMS   = NUM_ANIMS_DEF,
    parameter int unsigned FRAME_SLOTS = FRAME_SLOTS_DEF,
    parameter int unsigned TEX_BITS    = TEX_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_cmd                        i_cmd,
    input  wire logic                        i_cmd_empty,
    output logic                             o_cmd_pop,
    input  wire logic [$clog2(RESQ_DEPTH):0] i_res_count,
    output logic                             o_res_push,
    output t_result                          o_res
);

    localparam int unsigned DESC_DEPTH = (NUM_ANIMS < ID_SPACE) ? NUM_ANIMS : ID_SPACE;
    localparam int unsigned ID_W       = (DESC_DEPTH > 1) ? $clog2(DESC_DEPTH) : 1;
    localparam int unsigned SLOT_W     = $clog2(FRAME_SLOTS);
    localparam int unsigned CNT_W      = $clog2(RESQ_DEPTH) + 2;

    // (base + position) mod FRAME_SLOTS by restoring reduction; the sum is
    // below 512 and FRAME_SLOTS is at least 2, so eight steps suffice.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [8:0] v);
        logic [20:0] r;
        r = 21'(v);
        for (int k = 7; k >= 0; k--) begin
            if (r >= (21'(FRAME_SLOTS) << k)) begin
                r = r - (21'(FRAME_SLOTS) << k);
            end
        end
        return SLOT_W'(r);
    endfunction

    function automatic logic at_final(input t_desc d, input logic [7:0] pos);
        return d.rev ? (pos == '0) : (pos == d.last);
    endfunction

    t_desc               r_desc_tbl [DESC_DEPTH];
    logic [TEX_BITS-1:0] r_frame_mem [FRAME_SLOTS];

    logic        r_act_valid, n_act_valid;
    logic [3:0]  r_act_id, n_act_id;
    t_desc       r_act, n_act;
    logic [7:0]  r_pos, n_pos;
    logic [24:0] r_elapsed, n_elapsed;
    logic [7:0]  r_left, n_left;
    logic        r_block, n_block;

    logic        r_v1, r_taken1;
    logic        r_v2;
    t_result     r_res2;
    logic [TEX_BITS-1:0] r_rd;

    logic        go, taken, desc_we, frame_we;
    logic [ID_W-1:0]   desc_idx;
    logic [SLOT_W-1:0] wr_slot, rd_slot;
    logic [25:0] e_sum, e_diff;
    logic [24:0] e_sat;
    logic        e_ge;
    logic [7:0]  pos_s, left_s, left_dec;
    logic        finite;
    t_desc       sel_desc;
    t_result     stat1;

    // Results in flight count against the room left in the result queue.
    assign go = !i_cmd_empty &&
                ((CNT_W'(i_res_count) + CNT_W'(r_v1) + CNT_W'(r_v2)) < CNT_W'(RESQ_DEPTH));
    assign o_cmd_pop = go;

    assign desc_idx = ID_W'(i_cmd.id);
    assign wr_slot  = SLOT_W'(i_cmd.slot);
    assign sel_desc = r_desc_tbl[desc_idx];

    always_comb begin
        e_sum  = {1'b0, r_elapsed} + 26'(i_cmd.delta);
        e_sat  = e_sum[25] ? ELAPSED_MAX : e_sum[24:0];
        e_diff = {1'b0, e_sat} - {2'b0, r_act.tpf};
        e_ge   = !e_diff[25];
    end

    // One frame step of the active animation.
    always_comb begin
        finite   = (r_act.loops != '0);
        left_dec = (r_left != '0) ? r_left - 8'd1 : r_left;
        pos_s    = r_pos;
        left_s   = r_left;
        if (r_act.loop) begin
            if (!(finite && r_left == '0)) begin
                if (!r_act.rev) begin
                    if (r_pos >= r_act.last) begin
                        left_s = finite ? left_dec : r_left;
                        pos_s  = (finite && left_dec == '0) ? r_act.last : 8'd0;
                    end else begin
                        pos_s = r_pos + 8'd1;
                    end
                end else begin
                    if (r_pos == '0) begin
                        left_s = finite ? left_dec : r_left;
                        pos_s  = (finite && left_dec == '0) ? 8'd0 : r_act.last;
                    end else begin
                        pos_s = r_pos - 8'd1;
                    end
                end
            end
        end else begin
            if (!r_act.rev) begin
                if (r_pos < r_act.last) begin
                    pos_s = r_pos + 8'd1;
                end
            end else begin
                if (r_pos != '0) begin
                    pos_s = r_pos - 8'd1;
                end
            end
        end
    end

    always_comb begin
        n_act_valid = r_act_valid;
        n_act_id    = r_act_id;
        n_act       = r_act;
        n_pos       = r_pos;
        n_elapsed   = r_elapsed;
        n_left      = r_left;
        n_block     = r_block;
        taken       = 1'b0;
        desc_we     = 1'b0;
        frame_we    = 1'b0;
        if (go) begin
            unique case (i_cmd.kind)
                CMD_TICK: begin
                    if (r_act_valid) begin
                        n_elapsed = e_ge ? e_diff[24:0] : e_sat;
                        if (e_ge) begin
                            n_pos  = pos_s;
                            n_left = left_s;
                        end
                        if (!r_act.loop && at_final(r_act, n_pos)) begin
                            n_block = 1'b0;
                        end
                    end
                end
                CMD_SELECT: begin
                    if (i_cmd.id_ok && !(r_act_valid && r_act_id == i_cmd.id) && !r_block) begin
                        n_act       = sel_desc;
                        n_act_id    = i_cmd.id;
                        n_act_valid = 1'b1;
                        n_pos       = sel_desc.rev ? sel_desc.last : 8'd0;
                        n_elapsed   = '0;
                        n_left      = sel_desc.loops;
                        n_block     = sel_desc.block;
                        taken       = 1'b1;
                    end
                end
                CMD_WR_DESC: begin
                    desc_we = i_cmd.id_ok;
                end
                CMD_WR_FRAME: begin
                    frame_we = i_cmd.slot_ok;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_valid <= 1'b0;
            r_act_id    <= '0;
            r_act       <= '0;
            r_pos       <= '0;
            r_elapsed   <= '0;
            r_left      <= '0;
            r_block     <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            r_act_valid <= n_act_valid;
            r_act_id    <= n_act_id;
            r_act       <= n_act;
            r_pos       <= n_pos;
            r_elapsed   <= n_elapsed;
            r_left      <= n_left;
            r_block     <= n_block;
            r_v1        <= go;
            r_v2        <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_taken1 <= taken;
        if (desc_we) begin
            r_desc_tbl[desc_idx] <= i_cmd.desc;
        end
    end

    // The state registers now hold the outcome of the command in stage one.
    assign rd_slot = slot_of(9'(r_act.base) + 9'(r_pos));

    always_comb begin
        stat1.texture_index  = '0;
        stat1.texture_valid  = r_act_valid;
        stat1.frame_position = r_pos;
        stat1.finished       = r_act_valid ? (!r_act.loop && at_final(r_act, r_pos)) : 1'b1;
        stat1.is_blocking    = r_block;
        stat1.change_taken   = r_taken1;
    end

    // Read-first frame table: a write by the next command is not seen by this read.
    always_ff @(posedge i_clk) begin
        if (frame_we) begin
            r_frame_mem[wr_slot] <= TEX_BITS'(i_cmd.tex);
        end
        r_rd   <= r_frame_mem[rd_slot];
        r_res2 <= stat1;
    end

    always_comb begin
        o_res = r_res2;
        o_res.texture_index = r_res2.texture_valid ? 8'(r_rd) : 8'd0;
    end
    assign o_res_push = r_v2;

endmodule

`default_nettype wire

FILE: sv/sprite_animation_sequencer.sv
// Top level of the sprite animation sequencer.
//
//   channel   direction  handshake         transfer when
//   command   in         push / full       push high, full low
//   result    out        empty / pop       pop high, empty low
//
// One command is taken per clock cycle when neither queue backs up.
// A result reaches the outputs after its command's transfer through execution into the
// state registers, the registered frame-table read and the result queue, in that order.
// The command queue holds two entries and the result queue four; execution
// stalls while the result queue plus results in flight would overflow it.
// Reset is synchronous and empties both queues; tables keep their contents.
`default_nettype none

module sprite_animation_sequencer import sas_pkg::*; #(
    parameter int unsigned NUM_ANIMS   = NUM_ANIMS_DEF,
    parameter int unsigned FRAME_SLOTS = FRAME_SLOTS_DEF,
    parameter int unsigned TEX_BITS    = TEX_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_command,
    input  wire logic [3:0]  i_anim_id,
    input  wire logic [15:0] i_delta_time,
    input  wire logic [7:0]  i_frame_slot,
    input  wire logic [7:0]  i_texture_id,
    input  wire logic [7:0]  i_frame_base,
    input  wire logic [8:0]  i_frame_count,
    input  wire logic [23:0] i_time_per_frame,
    input  wire logic        i_reverse_flag,
    input  wire logic        i_loop_flag,
    input  wire logic [7:0]  i_loop_count,
    input  wire logic        i_block_flag,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_texture_index,
    output logic             o_texture_valid,
    output logic [7:0]       o_frame_position,
    output logic             o_finished,
    output logic             o_is_blocking,
    output logic             o_change_taken
);

    t_cmd    cmd;
    logic    cmd_empty, cmd_pop;
    logic    res_push;
    t_result res_in, res_out;
    logic [$bits(t_result)-1:0] res_q;
    logic [$clog2(RESQ_DEPTH):0] res_count;

    sas_front #(
        .NUM_ANIMS   (NUM_ANIMS),
        .FRAME_SLOTS (FRAME_SLOTS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_command        (i_command),
        .i_anim_id        (i_anim_id),
        .i_delta_time     (i_delta_time),
        .i_frame_slot     (i_frame_slot),
        .i_texture_id     (i_texture_id),
        .i_frame_base     (i_frame_base),
        .i_frame_count    (i_frame_count),
        .i_time_per_frame (i_time_per_frame),
        .i_reverse_flag   (i_reverse_flag),
        .i_loop_flag      (i_loop_flag),
        .i_loop_count     (i_loop_count),
        .i_block_flag     (i_block_flag),
        .i_pop            (cmd_pop),
        .o_cmd            (cmd),
        .o_empty          (cmd_empty)
    );

    sas_back #(
        .NUM_ANIMS   (NUM_ANIMS),
        .FRAME_SLOTS (FRAME_SLOTS),
        .TEX_BITS    (TEX_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_count (res_count),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    sas_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RESQ_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty),
        .o_count (res_count)
    );

    assign res_out          = t_result'(res_q);
    assign o_texture_index  = res_out.texture_index;
    assign o_texture_valid  = res_out.texture_valid;
    assign o_frame_position = res_out.frame_position;
    assign o_finished       = res_out.finished;
    assign o_is_blocking    = res_out.is_blocking;
    assign o_change_taken   = res_out.change_taken;

endmodule

`default_nettype wire

FILE: sv/sas_checker.sv
// Port-level checks for the sprite animation sequencer and their binding.
`default_nettype none

module sas_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] o_texture_index,
    input wire logic       o_texture_valid,
    input wire logic [7:0] o_frame_position,
    input wire logic       o_finished,
    input wire logic       o_is_blocking,
    input wire logic       o_change_taken
);

    // Reset drops every queued result.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // A waiting result that is not taken stays put.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_texture_index) &&
                              $stable(o_frame_position) && $stable(o_finished)))
        else $error("waiting result changed before its transfer");

    // Before any animation is active, the status is the idle one.
    a_idle_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_texture_valid) |-> (o_finished && !o_is_blocking &&
                                          o_frame_position == 8'd0 &&
                                          o_texture_index == 8'd0))
        else $error("inactive result shows animation status");

    // A switch or a block can only come with an active animation.
    a_taken_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_change_taken || o_is_blocking)) |-> o_texture_valid)
        else $error("switch or block reported without an active animation");

endmodule

bind sprite_animation_sequencer sas_checker u_sas_checker (.*);

`default_nettype wire
